@@ src/set_assoc_cache_lru_model_defines.svh @@
// Assertion macros shared by the cache model RTL.
`ifndef SET_ASSOC_CACHE_LRU_MODEL_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_MODEL_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SACL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SACL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sacl_pkg.sv @@
package sacl_pkg;

    // Default geometry
    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_ADDR_WIDTH   = 64;

    // Field widths
    localparam int ACTION_W   = 2;
    localparam int ADDRESS_W  = 64;
    localparam int OUTCOME_W  = 2;
    localparam int WAY_OUT_W  = 3;
    localparam int COUNT_W    = 32;
    localparam int OUT_DATA_W = 104;  // 3 + 3*32 = 99 bits, padded to whole bytes

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int SET_BITS_W   = 3;
    localparam int BLOCK_BITS_W = 6;
    localparam int WAYS_IN_W    = 4;
    localparam int BLOCK_BITS_MAX = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd2;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_STORE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_MODIFY = 2'd2;

    // Outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_FILL  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_REREAD
    } sacl_state_t;

endpackage

@@ src/set_assoc_cache_lru_model.sv @@
// Tag-only set-associative cache with true LRU replacement. Each input word
// (tuser = action, tdata = byte address) is split into set and tag by the
// configured set_bits and block_bits; the result word reports hit, fill of the
// lowest empty way or eviction of the oldest way, plus the running hit, miss
// and eviction totals. Each set is one row of on-chip memory (valid bits, tags
// and ages of all ways) with a registered read: an access first reads the
// row, then compares, picks the way and writes the row back; a modify makes
// two accesses and two result words. The result sits in an output register,
// so the next word is taken while it waits; lookup stalls only if the
// previous result has not yet been taken. After reset and after every
// register write the memory is swept once, one set per cycle, over all
// 2^MAX_SET_BITS sets (64 by default); no input word is taken during the
// sweep and the totals keep their values.
`include "set_assoc_cache_lru_model_defines.svh"

module set_assoc_cache_lru_model #(
    parameter int MAX_SET_BITS = sacl_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = sacl_pkg::DEF_MAX_WAYS,
    parameter int ADDR_WIDTH   = sacl_pkg::DEF_ADDR_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sacl_pkg::ADDRESS_W-1:0]      s_tdata,   // [63:0] address
    input  logic [sacl_pkg::ACTION_W-1:0]       s_tuser,   // [1:0] action
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [2:0] way_used, [34:3] hit_total, [66:35] miss_total,
    // [98:67] eviction_total, [103:99] zero
    output logic [sacl_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [sacl_pkg::OUTCOME_W-1:0]      m_tuser,   // [1:0] outcome
    output logic                                m_tlast    // last_of_run
);
    import sacl_pkg::*;

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AGE_W    = WAY_W;
    localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
    localparam int SH_W     = 7;

    // Set-row memories
    logic [MAX_WAYS-1:0]                  valid_mem [NUM_SETS];
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  tag_mem   [NUM_SETS];
    logic [MAX_WAYS-1:0][AGE_W-1:0]       age_mem   [NUM_SETS];

    logic [MAX_WAYS-1:0]                  rd_valid_reg;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  rd_tag_reg;
    logic [MAX_WAYS-1:0][AGE_W-1:0]       rd_age_reg;

    // Control and configuration
    sacl_state_t               state_reg, state_next;
    logic [SET_W-1:0]          clr_idx_reg, clr_idx_next;
    logic [SET_BITS_W-1:0]     set_bits_reg;
    logic [BLOCK_BITS_W-1:0]   block_bits_reg;
    logic [WAYS_IN_W-1:0]      ways_reg;
    logic                      modify_reg;
    logic [SET_W-1:0]          set_reg;
    logic [ADDR_WIDTH-1:0]     tag_reg;
    logic [COUNT_W-1:0]        hit_reg, hit_next;
    logic [COUNT_W-1:0]        miss_reg, miss_next;
    logic [COUNT_W-1:0]        evict_reg, evict_next;

    // Output register
    logic                      out_valid_reg;
    logic [OUTCOME_W-1:0]      out_outcome_reg;
    logic [WAY_OUT_W-1:0]      out_way_reg;
    logic [COUNT_W-1:0]        out_hit_reg;
    logic [COUNT_W-1:0]        out_miss_reg;
    logic [COUNT_W-1:0]        out_evict_reg;
    logic                      out_last_reg;

    // Combinational signals
    logic [SET_BITS_W-1:0]     eff_sb;
    logic [BLOCK_BITS_W-1:0]   eff_bb;
    logic [WCNT_W-1:0]         eff_ways;
    logic [ADDR_WIDTH-1:0]     acc_addr;
    logic [ADDR_WIDTH-1:0]     acc_shifted;
    logic [SET_W-1:0]          acc_set;
    logic [ADDR_WIDTH-1:0]     acc_tag;

    logic [MAX_WAYS-1:0]       used;
    logic [MAX_WAYS-1:0]       match;
    logic [MAX_WAYS-1:0]       empty;
    logic [MAX_WAYS-1:0]       oldest;
    logic                      hit_found;
    logic                      fill_found;
    logic [WAY_W-1:0]          hit_way, fill_way, old_way, sel_way;
    logic [MAX_WAYS-1:0]       sel_mask;
    logic [OUTCOME_W-1:0]      res_outcome;
    logic [AGE_W-1:0]          sel_age;

    logic [MAX_WAYS-1:0]                  new_valid;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  new_tag;
    logic [MAX_WAYS-1:0][AGE_W-1:0]       new_age;
    logic [MAX_WAYS-1:0][AGE_W-1:0]       init_age;

    logic                      cfg_flush;
    logic                      in_accept;
    logic                      do_look;
    logic                      load_out;
    logic                      rd_en;
    logic [SET_W-1:0]          rd_addr;
    logic                      mem_we;
    logic                      tag_we;
    logic [SET_W-1:0]          wr_addr;
    logic [MAX_WAYS-1:0]                  wr_valid;
    logic [MAX_WAYS-1:0][AGE_W-1:0]       wr_age;

    assign cfg_ready = 1'b1;
    assign cfg_flush = cfg_valid
                    && (cfg_index == REG_SET_BITS || cfg_index == REG_BLOCK_BITS
                        || cfg_index == REG_WAYS);
    assign in_accept = s_tvalid && s_tready;
    assign do_look   = (state_reg == ST_LOOK) && (!out_valid_reg || m_tready);

    // Effective configuration, saturated
    always_comb
    begin
        if (int'(set_bits_reg) > MAX_SET_BITS)
            eff_sb = SET_BITS_W'(MAX_SET_BITS);
        else
            eff_sb = set_bits_reg;

        if (int'(block_bits_reg) > BLOCK_BITS_MAX)
            eff_bb = BLOCK_BITS_W'(BLOCK_BITS_MAX);
        else
            eff_bb = block_bits_reg;

        if (ways_reg == '0)
            eff_ways = WCNT_W'(1);
        else if (int'(ways_reg) > MAX_WAYS)
            eff_ways = WCNT_W'(MAX_WAYS);
        else
            eff_ways = WCNT_W'(ways_reg);
    end

    // Address split into set and tag
    always_comb
    begin
        acc_addr    = s_tdata[ADDR_WIDTH-1:0];
        acc_shifted = acc_addr >> eff_bb;
        acc_set     = acc_shifted[SET_W-1:0] & ~({SET_W{1'b1}} << eff_sb);
        acc_tag     = acc_addr >> (SH_W'(eff_bb) + SH_W'(eff_sb));
    end

    // Way compare, victim choice and row update
    always_comb
    begin
        hit_way  = '0;
        fill_way = '0;
        old_way  = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            used[w]   = w < int'(eff_ways);
            match[w]  = used[w] && rd_valid_reg[w] && (rd_tag_reg[w] == tag_reg);
            empty[w]  = used[w] && !rd_valid_reg[w];
            // ages of the used ways are a permutation, so the oldest is ways-1
            oldest[w] = used[w] && (int'(rd_age_reg[w]) == int'(eff_ways) - 1);
            init_age[w] = AGE_W'(w);
        end
        // lowest-numbered way wins
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
                hit_way = WAY_W'(w);
            if (empty[w])
                fill_way = WAY_W'(w);
            if (oldest[w])
                old_way = WAY_W'(w);
        end
        hit_found  = |match;
        fill_found = |empty;

        priority if (hit_found)
        begin
            sel_way     = hit_way;
            res_outcome = OUT_HIT;
        end
        else if (fill_found)
        begin
            sel_way     = fill_way;
            res_outcome = OUT_FILL;
        end
        else
        begin
            sel_way     = old_way;
            res_outcome = OUT_EVICT;
        end

        sel_mask = '0;
        sel_mask[sel_way] = 1'b1;
        sel_age  = rd_age_reg[sel_way];

        new_valid = rd_valid_reg | sel_mask;
        new_tag   = rd_tag_reg;
        new_tag[sel_way] = tag_reg;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (sel_mask[w])
                new_age[w] = '0;
            else if (used[w] && (rd_age_reg[w] < sel_age))
                new_age[w] = rd_age_reg[w] + AGE_W'(1);
            else
                new_age[w] = rd_age_reg[w];
        end

        hit_next   = hit_reg + COUNT_W'(hit_found);
        miss_next  = miss_reg + COUNT_W'(!hit_found);
        evict_next = evict_reg + COUNT_W'(!hit_found && !fill_found);
    end

    // Sequencer: next state and memory controls
    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        s_tready     = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = set_reg;
        mem_we       = 1'b0;
        tag_we       = 1'b0;
        wr_addr      = set_reg;
        wr_valid     = new_valid;
        wr_age       = new_age;
        load_out     = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                wr_addr  = clr_idx_reg;
                wr_valid = '0;
                wr_age   = init_age;
                if (clr_idx_reg == SET_W'(NUM_SETS - 1))
                    state_next = ST_IDLE;
                else
                    clr_idx_next = clr_idx_reg + SET_W'(1);
            end
            ST_IDLE:
            begin
                s_tready = !cfg_valid;
                if (s_tvalid && !cfg_valid)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = acc_set;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (do_look)
                begin
                    mem_we   = 1'b1;
                    tag_we   = 1'b1;
                    load_out = 1'b1;
                    state_next = modify_reg ? ST_REREAD : ST_IDLE;
                end
            end
            ST_REREAD:
            begin
                // second access of a modify sees the row just written
                rd_en      = 1'b1;
                state_next = ST_LOOK;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        // register write flushes the cache
        if (cfg_flush)
        begin
            state_next   = ST_CLEAR;
            clr_idx_next = '0;
        end
    end

    // Set-row memories, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            valid_mem[wr_addr] <= wr_valid;
            age_mem[wr_addr]   <= wr_age;
        end
        if (tag_we)
            tag_mem[wr_addr] <= new_tag;
        if (rd_en)
        begin
            rd_valid_reg <= valid_mem[rd_addr];
            rd_tag_reg   <= tag_mem[rd_addr];
            rd_age_reg   <= age_mem[rd_addr];
        end
    end

    // State, configuration and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            set_bits_reg   <= '0;
            block_bits_reg <= '0;
            ways_reg       <= WAYS_IN_W'(1);
            modify_reg     <= 1'b0;
            hit_reg        <= '0;
            miss_reg       <= '0;
            evict_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_SET_BITS:   set_bits_reg   <= cfg_data[SET_BITS_W-1:0];
                    REG_BLOCK_BITS: block_bits_reg <= cfg_data[BLOCK_BITS_W-1:0];
                    REG_WAYS:       ways_reg       <= cfg_data[WAYS_IN_W-1:0];
                    default:        ;
                endcase
            end
            if (in_accept)
                modify_reg <= (s_tuser == ACT_MODIFY);
            else if (do_look)
                modify_reg <= 1'b0;
            if (do_look)
            begin
                hit_reg   <= hit_next;
                miss_reg  <= miss_next;
                evict_reg <= evict_next;
            end
        end
    end

    // Access payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            set_reg <= acc_set;
            tag_reg <= acc_tag;
        end
    end

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_outcome_reg <= res_outcome;
            out_way_reg     <= WAY_OUT_W'(sel_way);
            out_hit_reg     <= hit_next;
            out_miss_reg    <= miss_next;
            out_evict_reg   <= evict_next;
            out_last_reg    <= !modify_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_outcome_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {(OUT_DATA_W - WAY_OUT_W - 3 * COUNT_W)'(0),
                       out_evict_reg, out_miss_reg, out_hit_reg, out_way_reg};

    // Checks
    `SACL_ASSERT_NOW(a_no_accept_in_clear, state_reg == ST_CLEAR, !s_tready,
        "input word taken during clearing sweep")
    `SACL_ASSERT_NOW(a_one_way_selected, do_look, $onehot(sel_mask) && used[sel_way],
        "lookup did not select exactly one used way")
    `SACL_ASSERT_NEXT(a_hit_counts, do_look && hit_found, hit_reg == $past(hit_reg) + 32'd1,
        "hit total not advanced on hit")
    `SACL_ASSERT_NEXT(a_flush_starts_sweep, cfg_flush,
        state_reg == ST_CLEAR && clr_idx_reg == '0,
        "register write did not restart clearing sweep")

endmodule
